// ===== sv/wrcp_pkg.sv =====
// Shared types and constants for the WAV RIFF chunk parser.
package wrcp_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  // Up to two results per input byte travel as one bundle.
  typedef struct packed {
    logic      first_vld;
    out_item_t first;
    logic      second_vld;
    out_item_t second;
  } res_pair_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FMT  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] ERR_HDR     = 2'd0;
  localparam logic [1:0] ERR_NON_PCM = 2'd1;
  localparam logic [1:0] ERR_MISSING = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [15:0] PCM_TAG  = 16'd1;

  function automatic out_item_t mk_res(logic [1:0] kind, logic [7:0] db,
                                       logic [15:0] ch, logic [31:0] rate,
                                       logic [15:0] bits, logic [1:0] err,
                                       logic last);
    out_item_t r;
    r.kind = kind;
    r.data_byte = db;
    r.channel_count = ch;
    r.sample_rate = rate;
    r.sample_bits = bits;
    r.error_code = err;
    r.last = last;
    return r;
  endfunction

endpackage

// ===== sv/wrcp_front.sv =====
// Front end: walks RIFF one byte per cycle unless stalled, emits result pairs.
module wrcp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrcp_pkg::in_item_t  in_data,
  output logic                pair_valid_o,
  input  logic                pair_ready_i,
  output wrcp_pkg::res_pair_t pair_o
);
  import wrcp_pkg::*;

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_CHUNK = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;
  localparam logic [2:0] PH_PAD   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        seen_fmt_q, seen_fmt_d;
  logic        seen_pay_q, seen_pay_d;
  logic        cnt_small, cnt_is1;
  logic [3:0]  idx;
  logic [7:0]  b;
  logic [31:0] len_new;
  logic [31:0] tag_shift;
  res_pair_t   pair;
  logic        err_now;
  logic        fire;

  assign in_ready     = pair_ready_i;
  assign pair_valid_o = in_valid;
  assign fire         = in_valid && pair_ready_i;
  assign b            = in_data.byte_in;
  assign idx          = cnt_q[3:0];
  assign cnt_small    = (cnt_q[31:4] == 28'd0);
  assign cnt_is1      = (cnt_q == 32'd1);
  assign tag_shift    = {tag_q[23:0], b};

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; tag_d = tag_q; len_d = len_q;
    fmt_d = fmt_q; ch_d = ch_q; rate_d = rate_q; bits_d = bits_q;
    seen_fmt_d = seen_fmt_q; seen_pay_d = seen_pay_q;
    pair = '0;
    err_now = 1'b0;
    len_new = len_q;
    unique case (phase_q)
      PH_HDR: begin
        if (idx < 4'd4 || idx >= 4'd8) tag_d = tag_shift;
        if (idx == 4'd3 && tag_shift != TAG_RIFF) begin
          pair.first_vld = 1'b1;
          pair.first = mk_res(KIND_ERR, '0, '0, '0, '0, ERR_HDR, 1'b1);
          phase_d = PH_ERR; err_now = 1'b1;
        end else if (idx == 4'd11) begin
          if (tag_shift != TAG_WAVE) begin
            pair.first_vld = 1'b1;
            pair.first = mk_res(KIND_ERR, '0, '0, '0, '0, ERR_HDR, 1'b1);
            phase_d = PH_ERR; err_now = 1'b1;
          end else begin
            phase_d = PH_CHUNK; cnt_d = '0;
          end
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      PH_CHUNK: begin
        if (idx < 4'd4) begin
          tag_d = tag_shift;
          if (idx == 4'd0) len_new = '0;
        end else begin
          case (idx[1:0])
            2'd0: len_new[7:0]   = b;
            2'd1: len_new[15:8]  = b;
            2'd2: len_new[23:16] = b;
            default: len_new[31:24] = b;
          endcase
        end
        len_d = len_new;
        cnt_d = cnt_q + 32'd1;
        if (idx == 4'd7) begin
          cnt_d = '0;
          if (tag_q == TAG_FMT) begin
            phase_d = PH_FMT;
            fmt_d = '0; ch_d = '0; rate_d = '0; bits_d = '0;
          end else if (len_new == 32'd0) begin
            phase_d = len_new[0] ? PH_PAD : PH_CHUNK;
          end else begin
            phase_d = (tag_q == TAG_DATA) ? PH_DATA : PH_SKIP;
            cnt_d = len_new;
          end
        end
      end
      PH_FMT: begin
        case (idx)
          4'd0: fmt_d[7:0] = b;
          4'd1: fmt_d[15:8] = b;
          4'd2: ch_d[7:0] = b;
          4'd3: ch_d[15:8] = b;
          4'd4: rate_d[7:0] = b;
          4'd5: rate_d[15:8] = b;
          4'd6: rate_d[23:16] = b;
          4'd7: rate_d[31:24] = b;
          4'd14: bits_d[7:0] = b;
          4'd15: bits_d[15:8] = b;
          default: ;
        endcase
        cnt_d = cnt_q + 32'd1;
        if (!cnt_small || idx == 4'd15) begin
          if (fmt_q != PCM_TAG) begin
            pair.first_vld = 1'b1;
            pair.first = mk_res(KIND_ERR, '0, '0, '0, '0, ERR_NON_PCM, 1'b1);
            phase_d = PH_ERR; err_now = 1'b1;
          end else begin
            pair.first_vld = 1'b1;
            pair.first = mk_res(KIND_FMT, '0, ch_q, rate_q, bits_d, ERR_HDR, 1'b0);
            seen_fmt_d = 1'b1;
            if (len_q > FMT_BODY) begin
              phase_d = PH_SKIP; cnt_d = len_q - FMT_BODY;
            end else begin
              phase_d = len_q[0] ? PH_PAD : PH_CHUNK; cnt_d = '0;
            end
          end
        end
      end
      PH_DATA, PH_SKIP: begin
        if (phase_q == PH_DATA) begin
          pair.first_vld = 1'b1;
          pair.first = mk_res(KIND_DATA, b, '0, '0, '0, ERR_HDR, 1'b0);
          seen_pay_d = 1'b1;
        end
        cnt_d = cnt_q - 32'd1;
        if (cnt_is1) begin
          phase_d = len_q[0] ? PH_PAD : PH_CHUNK; cnt_d = '0;
        end
      end
      PH_PAD: begin
        phase_d = PH_CHUNK; cnt_d = '0;
      end
      default: ;
    endcase

    if (in_data.end_of_stream) begin
      if (!err_now && phase_q != PH_ERR) begin
        if (phase_d == PH_HDR)
          pair.second = mk_res(KIND_ERR, '0, '0, '0, '0, ERR_HDR, 1'b1);
        else if (seen_fmt_d && seen_pay_d)
          pair.second = mk_res(KIND_OK, '0, '0, '0, '0, ERR_HDR, 1'b1);
        else
          pair.second = mk_res(KIND_ERR, '0, '0, '0, '0, ERR_MISSING, 1'b1);
        pair.second_vld = 1'b1;
      end
      phase_d = PH_HDR; cnt_d = '0; tag_d = '0; len_d = '0;
      fmt_d = '0; ch_d = '0; rate_d = '0; bits_d = '0;
      seen_fmt_d = 1'b0; seen_pay_d = 1'b0;
    end
  end

  assign pair_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; cnt_q <= '0; tag_q <= '0; len_q <= '0;
      fmt_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0;
      seen_fmt_q <= 1'b0; seen_pay_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d; cnt_q <= cnt_d; tag_q <= tag_d; len_q <= len_d;
      fmt_q <= fmt_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
      seen_fmt_q <= seen_fmt_d; seen_pay_q <= seen_pay_d;
    end
  end
endmodule

// ===== sv/wrcp_queue.sv =====
// Two-entry queue of result pairs between the parser and the output stage.
module wrcp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  wrcp_pkg::res_pair_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output wrcp_pkg::res_pair_t rd_data_o
);
  import wrcp_pkg::*;

  res_pair_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== sv/wrcp_back.sv =====
// Back end: unrolls each queued pair into single results on the output channel.
module wrcp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pair_valid_i,
  output logic                pair_ready_o,
  input  wrcp_pkg::res_pair_t pair_i,
  output logic                out_valid,
  input  logic                out_ready,
  output wrcp_pkg::out_item_t out_data
);
  import wrcp_pkg::*;

  // Set once the first result of the head pair has gone out.
  logic first_done_q;
  logic has_first, has_second, take, head_done;

  assign has_first  = pair_i.first_vld && !first_done_q;
  assign has_second = pair_i.second_vld;
  assign out_valid  = pair_valid_i && (has_first || has_second);
  assign out_data   = has_first ? pair_i.first : pair_i.second;
  assign take       = out_valid && out_ready;
  // A pair with no results is dropped at once.
  assign head_done  = !(has_first || has_second) ||
                      (take && !(has_first && has_second));
  assign pair_ready_o = head_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_done_q <= 1'b0;
    else if (pair_valid_i && head_done) first_done_q <= 1'b0;
    else if (take && has_first) first_done_q <= 1'b1;
  end
endmodule

// ===== sv/wav_riff_chunk_parser.sv =====
// Top level of the WAV RIFF chunk parser.
// Input channel in_valid/in_ready carries one file byte and its end-of-stream
// flag per request. Output channel out_valid/out_ready carries result items:
// data bytes, format reports, and a final status or error with last set.
// The front end parses one byte per cycle while the queue has room, forms
// the zero to two results of each byte combinationally and writes them as
// one entry into a two-entry queue. The back end sends one result per cycle
// while out_ready is high; the two results of a byte (the final byte of a
// stream) go out one after the other. Data throughput is one byte per cycle
// while out_ready is high. Results are registered in the queue.
// Reset returns the parser to expect a RIFF header and empties the queue.
// When the receiver stalls, the queue fills and in_ready drops after two
// pending entries; no result is lost or repeated.
module wav_riff_chunk_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wrcp_pkg::out_item_t out_data
);
  import wrcp_pkg::*;

  logic      f_valid, f_ready, q_valid, q_ready;
  res_pair_t f_pair, q_pair;

  wrcp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .pair_valid_o(f_valid), .pair_ready_i(f_ready), .pair_o(f_pair)
  );

  wrcp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_pair),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_pair)
  );

  wrcp_back u_back (
    .clk_i, .rst_ni,
    .pair_valid_i(q_valid), .pair_ready_o(q_ready), .pair_i(q_pair),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ===== bench/wav_riff_chunk_parser_chk.sv =====
// Checker for the WAV RIFF chunk parser: predicts results and compares them.
module wav_riff_chunk_parser_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wrcp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wrcp_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wrcp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_CHUNK, PH_FMT, PH_DATA, PH_SKIP, PH_ERR, PH_PAD
  } parse_phase_e;

  parse_phase_e phase;
  logic [31:0] count, tag, clen, rate_h;
  logic [15:0] fmt_tag, chan_h, bits_h;
  logic        have_fmt, have_data;
  out_item_t   expected_results[$];

  function automatic out_item_t res(logic [1:0] k, logic [7:0] db, logic [15:0] ch,
                                    logic [31:0] r, logic [15:0] bi, logic [1:0] e,
                                    logic l);
    out_item_t o;
    o.kind = k; o.data_byte = db; o.channel_count = ch; o.sample_rate = r;
    o.sample_bits = bi; o.error_code = e; o.last = l;
    return o;
  endfunction

  task automatic clear_parser();
    phase = PH_HDR; count = 0; tag = 0; clen = 0; rate_h = 0;
    fmt_tag = 0; chan_h = 0; bits_h = 0; have_fmt = 0; have_data = 0;
  endtask

  task automatic end_body();
    phase = clen[0] ? PH_PAD : PH_CHUNK;
    count = 0;
  endtask

  task automatic parse_byte(in_item_t it);
    logic [7:0]  b;
    logic [31:0] i;
    logic        err_now;
    b = it.byte_in;
    i = count;
    err_now = 0;
    case (phase)
      PH_HDR: begin
        if (i < 4 || i >= 8) tag = {tag[23:0], b};
        if (i == 3 && tag != TAG_RIFF) begin
          expected_results.push_back(res(KIND_ERR, 0, 0, 0, 0, ERR_HDR, 1));
          phase = PH_ERR; err_now = 1;
        end else if (i == 11) begin
          if (tag != TAG_WAVE) begin
            expected_results.push_back(res(KIND_ERR, 0, 0, 0, 0, ERR_HDR, 1));
            phase = PH_ERR; err_now = 1;
          end else begin
            phase = PH_CHUNK; count = 0;
          end
        end else begin
          count = i + 1;
        end
      end
      PH_CHUNK: begin
        if (i < 4) begin
          tag = {tag[23:0], b};
          if (i == 0) clen = 0;
        end else begin
          clen = clen | (32'(b) << (8 * ((i - 4) & 3)));
        end
        count = i + 1;
        if (i == 7) begin
          count = 0;
          if (tag == TAG_FMT) begin
            phase = PH_FMT; fmt_tag = 0; chan_h = 0; rate_h = 0; bits_h = 0;
          end else if (clen == 0) begin
            end_body();
          end else begin
            phase = (tag == TAG_DATA) ? PH_DATA : PH_SKIP;
            count = clen;
          end
        end
      end
      PH_FMT: begin
        if (i < 2) fmt_tag = fmt_tag | (16'(b) << (8 * i));
        else if (i < 4) chan_h = chan_h | (16'(b) << (8 * (i - 2)));
        else if (i < 8) rate_h = rate_h | (32'(b) << (8 * (i - 4)));
        else if (i >= 14 && i < 16) bits_h = bits_h | (16'(b) << (8 * (i - 14)));
        count = i + 1;
        if (i >= FMT_BODY - 1) begin
          if (fmt_tag != PCM_TAG) begin
            expected_results.push_back(res(KIND_ERR, 0, 0, 0, 0, ERR_NON_PCM, 1));
            phase = PH_ERR; err_now = 1;
          end else begin
            expected_results.push_back(res(KIND_FMT, 0, chan_h, rate_h, bits_h, 0, 0));
            have_fmt = 1;
            if (clen > FMT_BODY) begin
              phase = PH_SKIP; count = clen - FMT_BODY;
            end else begin
              end_body();
            end
          end
        end
      end
      PH_DATA: begin
        expected_results.push_back(res(KIND_DATA, b, 0, 0, 0, 0, 0));
        have_data = 1;
        count = i - 1;
        if (count == 0) end_body();
      end
      PH_SKIP: begin
        count = i - 1;
        if (count == 0) end_body();
      end
      PH_PAD: begin
        phase = PH_CHUNK; count = 0;
      end
      default: ;
    endcase
    if (it.end_of_stream) begin
      if (!err_now && phase != PH_ERR) begin
        if (phase == PH_HDR)
          expected_results.push_back(res(KIND_ERR, 0, 0, 0, 0, ERR_HDR, 1));
        else if (have_fmt && have_data)
          expected_results.push_back(res(KIND_OK, 0, 0, 0, 0, 0, 1));
        else
          expected_results.push_back(res(KIND_ERR, 0, 0, 0, 0, ERR_MISSING, 1));
      end
      clear_parser();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_parser();
  end

  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result kind", out_data.kind, 0);
        end else begin
          w = expected_results.pop_front();
          if (out_data.kind != w.kind) report("kind", out_data.kind, w.kind);
          if (out_data.data_byte != w.data_byte)
            report("data_byte", out_data.data_byte, w.data_byte);
          if (out_data.channel_count != w.channel_count)
            report("channel_count", out_data.channel_count, w.channel_count);
          if (out_data.sample_rate != w.sample_rate)
            report("sample_rate", out_data.sample_rate, w.sample_rate);
          if (out_data.sample_bits != w.sample_bits)
            report("sample_bits", out_data.sample_bits, w.sample_bits);
          if (out_data.error_code != w.error_code)
            report("error_code", out_data.error_code, w.error_code);
          if (out_data.last != w.last) report("last", out_data.last, w.last);
        end
      end
      if (in_valid && in_ready) parse_byte(in_data);
      pending_count = expected_results.size();
    end
  end
endmodule

// ===== bench/wav_riff_chunk_parser_tb.sv =====
// Top of the WAV RIFF chunk parser testbench: stimulus, clock, reset and verdict.
module wav_riff_chunk_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wrcp_pkg::*;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;
  int        fail_count, pending_count;
  int        bytes_sent = 0;
  int        burst_left = 0;
  bit        hold_off = 0;
  logic [7:0] stream_bytes[$];

  wav_riff_chunk_parser dut (.*);

  wav_riff_chunk_parser_chk chk (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    #4000000;
    $display("wav_riff_chunk_parser: mismatch");
    $finish;
  end

  // Receiver stall pattern; a hold-off request first holds ready low.
  initial begin
    int phase_sel;
    phase_sel = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end else begin
        phase_sel = (bytes_sent / 150) % 3;
        case (phase_sel)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(3) != 0);
          default: out_ready <= ($urandom_range(1) == 0);
        endcase
      end
    end
  end

  // Valid stays high within a burst and drops only for a gap.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1;
    in_data.byte_in <= b;
    in_data.end_of_stream <= eos;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic push32(logic [31:0] v, bit le);
    for (int k = 0; k < 4; k++)
      stream_bytes.push_back(le ? v[8*k +: 8] : v[31-8*k -: 8]);
  endtask

  task automatic push_chunk_hdr(logic [31:0] t, logic [31:0] len);
    push32(t, 0);
    push32(len, 1);
  endtask

  // Format body: 18 bytes (tag, channels, rate, byte rate, align, bits, 2 random).
  task automatic push_fmt(logic [31:0] len, logic [15:0] ftag);
    push_chunk_hdr(TAG_FMT, len);
    stream_bytes.push_back(ftag[7:0]); stream_bytes.push_back(ftag[15:8]);
    push32({$urandom_range(1) ? 16'($urandom) : 16'hFFFF, 16'($urandom)}, 1);
    push32($urandom, 1);
    push32($urandom, 1);
    push32($urandom, 1);
    for (int k = 16; k < len; k++) stream_bytes.push_back($urandom);
    if (len[0]) stream_bytes.push_back($urandom);
  endtask

  task automatic push_body(logic [31:0] t, int len);
    push_chunk_hdr(t, len);
    for (int k = 0; k < len; k++) stream_bytes.push_back($urandom);
    if (len % 2) stream_bytes.push_back($urandom);
  endtask

  task automatic build_stream();
    int kind, nch;
    stream_bytes.delete();
    kind = $urandom_range(99);
    push32(TAG_RIFF, 0);
    push32($urandom, 1);
    push32(TAG_WAVE, 0);
    if (kind < 4) stream_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    else if (kind < 8) stream_bytes[8 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    nch = $urandom_range(1, 4);
    for (int c = 0; c < nch; c++) begin
      case ($urandom_range(5))
        0, 1: push_fmt($urandom_range(3) == 0 ? $urandom_range(19) : 16,
                       $urandom_range(9) == 0 ? 16'($urandom) : PCM_TAG);
        2, 3: push_body(TAG_DATA, $urandom_range(4) == 0 ? 0 : $urandom_range(1, 25));
        default: push_body($urandom, $urandom_range(7));
      endcase
    end
    // Truncated streams and pure noise exercise the early end paths.
    if ($urandom_range(9) == 0 && stream_bytes.size() > 1)
      repeat ($urandom_range(stream_bytes.size() - 1)) void'(stream_bytes.pop_back());
    if (kind >= 96) begin
      stream_bytes.delete();
      repeat ($urandom_range(1, 20)) stream_bytes.push_back($urandom);
    end
  endtask

  task automatic send_stream();
    for (int k = 0; k < stream_bytes.size(); k++)
      send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: file with a PCM fmt chunk and a data chunk, all-ones byte values included.
    stream_bytes.delete();
    push32(TAG_RIFF, 0); push32(32'hFFFF_FFFF, 1); push32(TAG_WAVE, 0);
    push_fmt(16, PCM_TAG);
    push_chunk_hdr(TAG_DATA, 3);
    stream_bytes.push_back(8'h00); stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h5A); stream_bytes.push_back(8'h00);
    send_stream();
    // Directed: bad first tag, then an end mark on a lone byte.
    stream_bytes.delete();
    push32(32'h52494647, 0); stream_bytes.push_back(8'hFF);
    send_stream();
    send_byte(8'h00, 1);
    // Pause until everything has come, then the long receiver hold-off.
    in_valid <= 0;
    drain();
    hold_off = 1;
    while (hold_off) begin
      build_stream();
      send_stream();
    end
    while (bytes_sent < 1250) begin
      build_stream();
      send_stream();
    end
    in_valid <= 0;
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("wav_riff_chunk_parser: match");
    end else begin
      $display("wav_riff_chunk_parser: mismatch");
    end
    $finish;
  end
endmodule
